FILE: hdl/cv3_pkg.sv
// ----------------------------------------------------------------------------
// cv3_pkg
// Shared constants, types and register codes for the 3x3 convolution filter.
// ----------------------------------------------------------------------------
`default_nettype none

package cv3_pkg;

  // line store depth and the widths that follow from it
  localparam int MAX_WIDTH = 2048;
  localparam int COL_W     = $clog2(MAX_WIDTH);
  localparam int PIX_W     = 8;
  localparam int LW_W      = 12;
  localparam int CMP_W     = ((COL_W > LW_W) ? COL_W : LW_W) + 1;

  // kernel arithmetic
  localparam int SUM_W = 13;
  localparam logic signed [SUM_W-1:0] SOBEL_OFFSET = SUM_W'(127);
  localparam logic signed [SUM_W-1:0] PIX_MAX      = SUM_W'(255);

  // configuration registers
  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] REG_LINE_WIDTH  = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KERNEL_MODE = 1'd1;
  localparam logic [LW_W-1:0]      LW_RESET        = 12'd640;
  localparam logic MODE_SOBEL   = 1'b0;
  localparam logic MODE_SHARPEN = 1'b1;

  // rows seen in the current run, saturating
  localparam logic [1:0] ROWS_FULL = 2'd2;

  // output queue
  localparam int FIFO_DEPTH = 4;
  localparam int PTR_W      = $clog2(FIFO_DEPTH);
  localparam int CNT_W      = $clog2(FIFO_DEPTH + 1);

  typedef logic [PIX_W-1:0] pix_t;
  typedef logic [COL_W-1:0] col_t;

  // one entry of the line store: rows one and two above
  typedef struct packed {
    pix_t above;
    pix_t two_above;
  } line_word_t;

  // controls of the item in the working stage
  typedef struct packed {
    logic       first_col;
    logic       last;
    logic       pad;
    logic [1:0] rows;
    pix_t       px;
  } s1_ctl_t;

  // one output word
  typedef struct packed {
    pix_t pixel;
    logic run_last;
    logic frame_end;
  } result_t;

endpackage

`default_nettype wire

FILE: hdl/conv3x3_sobel_sharpen_filter.sv
// ----------------------------------------------------------------------------
// conv3x3_sobel_sharpen_filter
// 3x3 convolution of a zero-padded grey image, Sobel-x or sharpen kernel.
// ----------------------------------------------------------------------------
// Pixels enter in raster order on the pixel channel (pix_valid / pix_stall);
// filtered words leave on the result channel (res_valid / res_stall). A word
// moves at a clock edge with valid high and stall low.
// Result for row r, column c is made by the pixel at row r+1, column c+1; the
// last pixel of a row also gives the right border word of the row above, so
// it makes two words. After the last image row send one row of line_width
// words with pad_row set to flush the final output row and end the run.
// Throughput: one pixel per cycle while the queue has room for a pair, set by
// one line store read and one write per cycle and one kernel pass per item; a
// row end puts two words into the output queue, which drains them at one word
// per cycle while the receiver does not stall. A pixel is registered in the
// working stage and its words are then written into the output queue.
// The user writes configuration (cfg_valid / cfg_ready, always ready) only
// while idle; the block does not enforce it. Index 0: line_width, 1: kernel_mode.
// Reset empties the pipeline and output queue, sets line_width to 640, Sobel
// mode, and starts a new run; line store contents are not cleared.
// When the receiver stalls, the head word holds and the queue fills; pix_stall
// rises once the queue cannot take a further pair of words.
// ----------------------------------------------------------------------------
`default_nettype none

module conv3x3_sobel_sharpen_filter (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           pix_valid,
  output logic                                pix_stall,
  input  wire logic [7:0]                     pixel_in,
  input  wire logic                           pad_row,
  output logic                                res_valid,
  input  wire logic                           res_stall,
  output logic [7:0]                          pixel_out,
  output logic                                run_last,
  output logic                                frame_end,
  input  wire logic                           cfg_valid,
  output logic                                cfg_ready,
  input  wire logic [cv3_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [cv3_pkg::LW_W-1:0]       cfg_data
);
  import cv3_pkg::*;

  logic [LW_W-1:0]  line_width;
  logic             kernel_mode;
  col_t             column_count;
  logic [1:0]       row_count;

  logic [CMP_W-1:0] last_col;
  logic             last0;
  logic             accept;

  logic             s1_valid;
  col_t             s1_col;
  s1_ctl_t          s1_ctl;
  logic             s1_byp;
  line_word_t       s1_byp_word;
  logic             s1_fire;

  line_word_t       rd_q;
  line_word_t       col_word;
  line_word_t       wr_word;

  result_t          res0;
  result_t          res1;
  logic [1:0]       res_count;
  logic [1:0]       push_count;
  result_t          head;
  logic             room2;
  logic             pop;

  // configuration writes
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      line_width  <= LW_RESET;
      kernel_mode <= MODE_SOBEL;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_LINE_WIDTH:  line_width  <= cfg_data;
        REG_KERNEL_MODE: kernel_mode <= cfg_data[0];
        default: ;
      endcase
    end
  end

  // effective last column: a width of zero acts as one, above the store as full
  always_comb begin
    if (line_width == '0) begin
      last_col = '0;
    end else if (CMP_W'(line_width) > CMP_W'(MAX_WIDTH)) begin
      last_col = CMP_W'(MAX_WIDTH - 1);
    end else begin
      last_col = CMP_W'(line_width) - CMP_W'(1);
    end
  end

  assign last0     = (CMP_W'(column_count) >= last_col);
  assign s1_fire   = s1_valid && room2;
  assign pix_stall = s1_valid && !s1_fire;
  assign accept    = pix_valid && !pix_stall;

  // column and row position; column stays below the store depth
  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (accept) begin
      if (last0) begin
        column_count <= '0;
        if (pad_row) begin
          row_count <= '0;
        end else if (row_count != ROWS_FULL) begin
          row_count <= row_count + 2'd1;
        end
      end else begin
        column_count <= column_count + COL_W'(1);
      end
    end
  end

  // working stage valid
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (accept) begin
      s1_valid <= 1'b1;
    end else if (s1_fire) begin
      s1_valid <= 1'b0;
    end
  end

  // capture the item; note a same-column write landing with this read
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_col           <= column_count;
      s1_ctl.first_col <= (column_count == '0);
      s1_ctl.last      <= last0;
      s1_ctl.pad       <= pad_row;
      s1_ctl.rows      <= row_count;
      s1_ctl.px        <= pad_row ? '0 : pixel_in;
      s1_byp           <= s1_fire && (s1_col == column_count);
      s1_byp_word      <= wr_word;
    end
  end

  assign col_word        = s1_byp ? s1_byp_word : rd_q;
  assign wr_word.above     = s1_ctl.px;
  assign wr_word.two_above = col_word.above;

  cv3_line_store u_line (
    .clk     (clk),
    .rd_en   (accept),
    .rd_addr (column_count),
    .rd_q    (rd_q),
    .wr_en   (s1_fire),
    .wr_addr (s1_col),
    .wr_word (wr_word)
  );

  cv3_window u_window (
    .clk         (clk),
    .fire        (s1_fire),
    .ctl         (s1_ctl),
    .col_word    (col_word),
    .kernel_mode (kernel_mode),
    .res0        (res0),
    .res1        (res1),
    .res_count   (res_count)
  );

  // push results only when the stage moves on
  assign push_count = s1_fire ? res_count : 2'd0;
  assign pop        = res_valid && !res_stall;

  cv3_out_fifo u_fifo (
    .clk        (clk),
    .rst        (rst),
    .push_count (push_count),
    .push0      (res0),
    .push1      (res1),
    .pop        (pop),
    .head       (head),
    .not_empty  (res_valid),
    .room2      (room2)
  );

  assign pixel_out = head.pixel;
  assign run_last  = head.run_last;
  assign frame_end = head.frame_end;

endmodule

`default_nettype wire

FILE: hdl/cv3_line_store.sv
// ----------------------------------------------------------------------------
// cv3_line_store
// Two row memories sharing one address: registered read, single write port.
// ----------------------------------------------------------------------------
`default_nettype none

module cv3_line_store (
  input  wire logic               clk,
  input  wire logic               rd_en,
  input  wire cv3_pkg::col_t      rd_addr,
  output cv3_pkg::line_word_t     rd_q,
  input  wire logic               wr_en,
  input  wire cv3_pkg::col_t      wr_addr,
  input  wire cv3_pkg::line_word_t wr_word
);
  import cv3_pkg::*;

  pix_t line_above     [MAX_WIDTH];
  pix_t line_two_above [MAX_WIDTH];

  // write back the shifted column
  always_ff @(posedge clk) begin
    if (wr_en) begin
      line_above[wr_addr]     <= wr_word.above;
      line_two_above[wr_addr] <= wr_word.two_above;
    end
  end

  // fetch the column for the incoming pixel
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_q.above     <= line_above[rd_addr];
      rd_q.two_above <= line_two_above[rd_addr];
    end
  end

endmodule

`default_nettype wire

FILE: hdl/cv3_window.sv
// ----------------------------------------------------------------------------
// cv3_window
// 3x3 neighbourhood register and the two kernel evaluations per pixel.
// ----------------------------------------------------------------------------
`default_nettype none

module cv3_window (
  input  wire logic                clk,
  input  wire logic                fire,
  input  wire cv3_pkg::s1_ctl_t    ctl,
  input  wire cv3_pkg::line_word_t col_word,
  input  wire logic                kernel_mode,
  output cv3_pkg::result_t         res0,
  output cv3_pkg::result_t         res1,
  output logic [1:0]               res_count
);
  import cv3_pkg::*;

  typedef pix_t win_t [3][3];

  win_t window;
  win_t window_next;
  win_t edge_win;
  pix_t pix_main;
  pix_t pix_edge;
  logic have_rows;
  logic give_main;
  logic give_edge;

  function automatic logic signed [SUM_W-1:0] ext(input pix_t p);
    ext = $signed({{(SUM_W-PIX_W){1'b0}}, p});
  endfunction

  function automatic pix_t kernel_eval(input win_t w, input logic mode);
    logic signed [SUM_W-1:0] s;
    if (mode == MODE_SOBEL) begin
      s = SOBEL_OFFSET + ext(w[0][0]) + ext(w[2][0]) + (ext(w[1][0]) <<< 1)
          - ext(w[0][2]) - ext(w[2][2]) - (ext(w[1][2]) <<< 1);
    end else begin
      s = (ext(w[1][1]) <<< 3) + ext(w[1][1])
          - ext(w[0][0]) - ext(w[0][1]) - ext(w[0][2])
          - ext(w[1][0]) - ext(w[1][2])
          - ext(w[2][0]) - ext(w[2][1]) - ext(w[2][2]);
    end
    if (s < 0) begin
      kernel_eval = '0;
    end else if (s > PIX_MAX) begin
      kernel_eval = PIX_MAX[PIX_W-1:0];
    end else begin
      kernel_eval = s[PIX_W-1:0];
    end
  endfunction

  // shift the window left and bring in the new column; clear at row start
  always_comb begin
    for (int r = 0; r < 3; r++) begin
      window_next[r][0] = ctl.first_col ? '0 : window[r][1];
      window_next[r][1] = ctl.first_col ? '0 : window[r][2];
    end
    window_next[0][2] = ctl.rows[1] ? col_word.two_above : '0;
    window_next[1][2] = (|ctl.rows) ? col_word.above : '0;
    window_next[2][2] = ctl.px;
    for (int r = 0; r < 3; r++) begin
      edge_win[r][0] = window_next[r][1];
      edge_win[r][1] = window_next[r][2];
      edge_win[r][2] = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      window <= window_next;
    end
  end

  // evaluate the centre result and, at row end, the right border result
  assign pix_main  = kernel_eval(window_next, kernel_mode);
  assign pix_edge  = kernel_eval(edge_win, kernel_mode);
  assign have_rows = |ctl.rows;
  assign give_main = have_rows && !ctl.first_col;
  assign give_edge = have_rows && ctl.last;

  // pack the words in order, the last one carrying the end marks
  always_comb begin
    res1.pixel     = pix_edge;
    res1.run_last  = 1'b1;
    res1.frame_end = ctl.pad;
    if (give_main) begin
      res0.pixel     = pix_main;
      res0.run_last  = !give_edge;
      res0.frame_end = 1'b0;
    end else begin
      res0 = res1;
    end
    res_count = {1'b0, give_main} + {1'b0, give_edge};
  end

endmodule

`default_nettype wire

FILE: hdl/cv3_out_fifo.sv
// ----------------------------------------------------------------------------
// cv3_out_fifo
// Small result queue: takes up to two words a cycle, gives one.
// ----------------------------------------------------------------------------
`default_nettype none

module cv3_out_fifo (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic [1:0]       push_count,
  input  wire cv3_pkg::result_t push0,
  input  wire cv3_pkg::result_t push1,
  input  wire logic             pop,
  output cv3_pkg::result_t      head,
  output logic                  not_empty,
  output logic                  room2
);
  import cv3_pkg::*;

  result_t            slots [FIFO_DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;
  logic [PTR_W-1:0]   wr_ptr_plus1;

  assign wr_ptr_plus1 = wr_ptr + PTR_W'(1);

  // store incoming words
  always_ff @(posedge clk) begin
    if (push_count != 2'd0) begin
      slots[wr_ptr] <= push0;
    end
    if (push_count == 2'd2) begin
      slots[wr_ptr_plus1] <= push1;
    end
  end

  // advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      wr_ptr <= wr_ptr + PTR_W'(push_count);
      rd_ptr <= rd_ptr + PTR_W'(pop);
      count  <= count + CNT_W'(push_count) - CNT_W'(pop);
    end
  end

  assign head      = slots[rd_ptr];
  assign not_empty = (count != '0);
  assign room2     = (count <= CNT_W'(FIFO_DEPTH - 2));

endmodule

`default_nettype wire

FILE: hdl/cv3_checker.sv
// ----------------------------------------------------------------------------
// cv3_checker
// Port-level checks on the filter's channels, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module cv3_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       pix_stall,
  input wire logic       res_valid,
  input wire logic       res_stall,
  input wire logic [7:0] pixel_out,
  input wire logic       run_last,
  input wire logic       frame_end
);

  // hold a stalled result word
  assert property (@(posedge clk) disable iff (rst)
    res_valid && res_stall |=> res_valid && $stable(pixel_out) && $stable(run_last)
                                && $stable(frame_end))
    else $error("stalled result word changed");

  // end of frame is always the last word of its pixel
  assert property (@(posedge clk) disable iff (rst)
    res_valid && frame_end |-> run_last)
    else $error("frame_end without run_last");

  // reset drops the result queue
  assert property (@(posedge clk)
    rst |=> !res_valid)
    else $error("result valid after reset");

  // an empty queue never holds back the input
  assert property (@(posedge clk) disable iff (rst)
    !res_valid |-> !pix_stall)
    else $error("input stalled with empty result queue");

endmodule

bind conv3x3_sobel_sharpen_filter cv3_checker u_cv3_checker (
  .clk       (clk),
  .rst       (rst),
  .pix_stall (pix_stall),
  .res_valid (res_valid),
  .res_stall (res_stall),
  .pixel_out (pixel_out),
  .run_last  (run_last),
  .frame_end (frame_end)
);

`default_nettype wire
